// ----- hw/rtl/ptc_pkg.sv -----
package ptc_pkg;

    // Field widths
    localparam int RAW_W  = 16;
    localparam int CAL_W  = 16;
    localparam int CIDX_W = 2;
    localparam int PRES_W = 14;
    localparam int TEMP_W = 10;

    // Datapath widths (signed, sized for full input range)
    localparam int DT_W   = 18;   // dT
    localparam int D1M_W  = 17;   // raw_pressure - 7168
    localparam int OFF_W  = 29;   // OFF, Q12
    localparam int SENS_W = 28;   // SENS, Q10
    localparam int TQ_W   = 25;   // T, Q10
    localparam int PROD_W = 45;   // SENS * (D1 - 7168), Q10
    localparam int X_W    = 47;   // X, Q24
    localparam int PQ_W   = 52;   // P, Q29

    localparam int P_FRAC = 29;
    localparam int T_FRAC = 10;

    // Formula constants
    localparam int T_REF      = 20224;
    localparam int K4_BIAS    = 512;
    localparam int SENS_BASE  = 24576;
    localparam int D1_BIAS    = 7168;
    localparam int K6_BIAS    = 50;
    localparam int T_BASE_Q10 = 200 * 1024;
    localparam longint P_BASE_Q29 = 64'(2500) << 29;
    localparam int PRES_MAX   = 11000;
    localparam int TEMP_MAX   = 850;

    // Config register indexes
    localparam logic [CIDX_W-1:0] CAL1_IDX = 2'd0;
    localparam logic [CIDX_W-1:0] CAL2_IDX = 2'd1;
    localparam logic [CIDX_W-1:0] CAL3_IDX = 2'd2;
    localparam logic [CIDX_W-1:0] CAL4_IDX = 2'd3;

    typedef struct packed {
        logic [14:0] k1;
        logic [11:0] k2;
        logic [9:0]  k3;
        logic [9:0]  k4;
        logic [10:0] k5;
        logic [5:0]  k6;
    } t_coef;

    // Front end to back end
    typedef struct packed {
        logic                     valid;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic signed [D1M_W-1:0]  d1m;
        logic signed [TQ_W-1:0]   tq;
    } t_mid;

    // Back end to output stage
    typedef struct packed {
        logic                   valid;
        logic signed [PQ_W-1:0] pq;
        logic signed [TQ_W-1:0] tq;
    } t_tail;

    function automatic t_coef unpack_cal(
        input logic [CAL_W-1:0] w1,
        input logic [CAL_W-1:0] w2,
        input logic [CAL_W-1:0] w3,
        input logic [CAL_W-1:0] w4
    );
        t_coef c;
        c.k1 = w1[15:1];
        c.k2 = {w3[5:0], w4[5:0]};
        c.k3 = w4[15:6];
        c.k4 = w3[15:6];
        c.k5 = {w1[0], w2[15:6]};
        c.k6 = w2[5:0];
        return c;
    endfunction

endpackage

// ----- hw/rtl/ptc_front.sv -----
// Stages 1-2: dT and D1 offset, then OFF, SENS and T.
module ptc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [ptc_pkg::RAW_W-1:0]   i_raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]   i_raw_temperature,
    input  ptc_pkg::t_coef              i_coef,
    output ptc_pkg::t_mid               o_mid
);

    localparam int DT_W   = ptc_pkg::DT_W;
    localparam int D1M_W  = ptc_pkg::D1M_W;
    localparam int OFF_W  = ptc_pkg::OFF_W;
    localparam int SENS_W = ptc_pkg::SENS_W;
    localparam int TQ_W   = ptc_pkg::TQ_W;

    // Stage 1
    logic                    r_s1_valid;
    logic signed [DT_W-1:0]  r_dt,  n_dt;
    logic signed [D1M_W-1:0] r_d1m, n_d1m;

    // Stage 2
    ptc_pkg::t_mid           r_mid, n_mid;

    logic signed [10:0]      k4m;
    logic signed [10:0]      k3s;
    logic signed [7:0]       k6p;
    logic [15:0]             sbase;

    always_comb begin
        n_dt  = $signed({2'b00, i_raw_temperature})
              - $signed({4'b0000, i_coef.k5, 3'b000})
              - DT_W'(ptc_pkg::T_REF);
        n_d1m = $signed({1'b0, i_raw_pressure}) - D1M_W'(ptc_pkg::D1_BIAS);
    end

    always_comb begin
        k4m   = $signed({1'b0, i_coef.k4}) - 11'(ptc_pkg::K4_BIAS);
        k3s   = $signed({1'b0, i_coef.k3});
        k6p   = $signed({2'b00, i_coef.k6}) + 8'(ptc_pkg::K6_BIAS);
        sbase = 16'(ptc_pkg::SENS_BASE) + {1'b0, i_coef.k1};

        n_mid.valid = r_s1_valid;
        // OFF * 2^12 = k2 * 2^14 + (k4 - 512) * dT
        n_mid.off   = $signed({3'b000, i_coef.k2, 14'b0})
                    + OFF_W'(k4m) * OFF_W'(r_dt);
        // SENS * 2^10 = (24576 + k1) * 2^10 + k3 * dT
        n_mid.sens  = $signed({2'b00, sbase, 10'b0})
                    + SENS_W'(k3s) * SENS_W'(r_dt);
        n_mid.d1m   = r_d1m;
        // T * 2^10 = 200 * 2^10 + dT * (k6 + 50)
        n_mid.tq    = TQ_W'(ptc_pkg::T_BASE_Q10) + TQ_W'(k6p) * TQ_W'(r_dt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_mid      <= '0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_mid      <= n_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dt  <= n_dt;
            r_d1m <= n_d1m;
        end
    end

    assign o_mid = r_mid;

endmodule

// ----- hw/rtl/ptc_back.sv -----
// Stages 3-5: SENS * (D1 - 7168), X, then P in Q29. T rides along.
module ptc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  ptc_pkg::t_mid  i_mid,
    output ptc_pkg::t_tail o_tail
);

    localparam int OFF_W  = ptc_pkg::OFF_W;
    localparam int PROD_W = ptc_pkg::PROD_W;
    localparam int X_W    = ptc_pkg::X_W;
    localparam int PQ_W   = ptc_pkg::PQ_W;
    localparam int TQ_W   = ptc_pkg::TQ_W;

    // Stage 3
    logic                     r_s3_valid;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [OFF_W-1:0]  r_s3_off;
    logic signed [TQ_W-1:0]   r_s3_tq;

    // Stage 4
    logic                     r_s4_valid;
    logic signed [X_W-1:0]    r_x, n_x;
    logic signed [TQ_W-1:0]   r_s4_tq;

    // Stage 5
    ptc_pkg::t_tail           r_tail, n_tail;

    always_comb begin
        n_prod = PROD_W'($signed(i_mid.sens)) * PROD_W'($signed(i_mid.d1m));
        n_x    = X_W'(r_prod) - (X_W'(r_s3_off) <<< 12);
        // P * 2^29 = 2500 * 2^29 + 10 * X
        n_tail.valid = r_s4_valid;
        n_tail.pq    = PQ_W'(ptc_pkg::P_BASE_Q29)
                     + (PQ_W'(r_x) <<< 3) + (PQ_W'(r_x) <<< 1);
        n_tail.tq    = r_s4_tq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_tail     <= '0;
        end else if (i_en) begin
            r_s3_valid <= i_mid.valid;
            r_s4_valid <= r_s3_valid;
            r_tail     <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod    <= n_prod;
            r_s3_off  <= $signed(i_mid.off);
            r_s3_tq   <= $signed(i_mid.tq);
            r_x       <= n_x;
            r_s4_tq   <= r_s3_tq;
        end
    end

    assign o_tail = r_tail;

endmodule

// ----- hw/rtl/pressure_temperature_compensation.sv -----
// Pressure / temperature compensation for a piezoresistive sensor.
//
// Input channel (i_in_valid / o_in_ready) takes one item: a raw pressure
// and a raw temperature conversion. Output channel (o_out_valid /
// i_out_ready) returns one item per input: pressure in 0.1 mbar and
// temperature in 0.1 C, each with an invalid flag (field reads 0 when the
// flag is set: out of range, or negative at -1 or below).
// Calibration words 1..4 are loaded through i_cfg_we / i_cfg_idx /
// i_cfg_wdata, one write per cycle, and must be loaded while no item is
// in flight.
// Six register stages: five datapath stages plus the output register, the
// first loaded at the accepting edge. Throughput: one item per cycle while
// the output is not stalled.
// The longest stage is the 28x17 signed multiply forming SENS * (D1-7168).
// Stall: the whole pipeline advances together; when the output register
// holds an item the receiver has not taken, every stage holds and
// o_in_ready drops. Nothing is lost or duplicated.
// Reset (synchronous, active low) clears all valid bits and the four
// calibration words to zero.
module pressure_temperature_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ptc_pkg::CIDX_W-1:0]    i_cfg_idx,
    input  logic [ptc_pkg::CAL_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ptc_pkg::RAW_W-1:0]     i_raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]     i_raw_temperature,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ptc_pkg::PRES_W-1:0]    o_pressure_tenths_mbar,
    output logic [ptc_pkg::TEMP_W-1:0]    o_temperature_tenths_c,
    output logic                          o_pressure_invalid,
    output logic                          o_temperature_invalid
);

    localparam int PQ_W   = ptc_pkg::PQ_W;
    localparam int TQ_W   = ptc_pkg::TQ_W;
    localparam int P_FRAC = ptc_pkg::P_FRAC;
    localparam int T_FRAC = ptc_pkg::T_FRAC;
    localparam int PHI_W  = PQ_W - P_FRAC;
    localparam int THI_W  = TQ_W - T_FRAC;
    localparam int PRES_W = ptc_pkg::PRES_W;
    localparam int TEMP_W = ptc_pkg::TEMP_W;

    // Calibration words
    logic [ptc_pkg::CAL_W-1:0] r_cal1, r_cal2, r_cal3, r_cal4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal1 <= '0;
            r_cal2 <= '0;
            r_cal3 <= '0;
            r_cal4 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ptc_pkg::CAL1_IDX: r_cal1 <= i_cfg_wdata;
                ptc_pkg::CAL2_IDX: r_cal2 <= i_cfg_wdata;
                ptc_pkg::CAL3_IDX: r_cal3 <= i_cfg_wdata;
                ptc_pkg::CAL4_IDX: r_cal4 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Coefficients must be kept static by the user while items are in flight;
    // the block does not enforce this. Stages 1 and 2 read them straight from the registers.
    ptc_pkg::t_coef coef;
    assign coef = ptc_pkg::unpack_cal(r_cal1, r_cal2, r_cal3, r_cal4);

    // Global advance: move when the output slot is empty or being drained.
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    ptc_pkg::t_mid  mid;
    ptc_pkg::t_tail tail;

    ptc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (en),
        .i_valid           (i_in_valid),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_coef            (coef),
        .o_mid             (mid)
    );

    ptc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_mid   (mid),
        .o_tail  (tail)
    );

    // Output stage: truncate toward zero, range check.
    // Arithmetic shift gives floor; a negative value with floor -1 and a
    // nonzero fraction lies in (-1, 0), truncates to 0 and is valid.
    logic signed [PHI_W-1:0] p_hi;
    logic signed [THI_W-1:0] t_hi;
    logic                    p_neg, t_neg, p_frac_nz, t_frac_nz;
    logic                    n_p_bad, n_t_bad;
    logic [PRES_W-1:0]       n_p_val;
    logic [TEMP_W-1:0]       n_t_val;

    always_comb begin
        p_hi      = $signed(tail.pq[PQ_W-1:P_FRAC]);
        t_hi      = $signed(tail.tq[TQ_W-1:T_FRAC]);
        p_neg     = tail.pq[PQ_W-1];
        t_neg     = tail.tq[TQ_W-1];
        p_frac_nz = |tail.pq[P_FRAC-1:0];
        t_frac_nz = |tail.tq[T_FRAC-1:0];

        if (p_neg) begin
            n_p_bad = !((p_hi == -PHI_W'(1)) && p_frac_nz);
        end else begin
            n_p_bad = p_hi > PHI_W'(ptc_pkg::PRES_MAX);
        end
        if (t_neg) begin
            n_t_bad = !((t_hi == -THI_W'(1)) && t_frac_nz);
        end else begin
            n_t_bad = t_hi > THI_W'(ptc_pkg::TEMP_MAX);
        end

        n_p_val = (p_neg || n_p_bad) ? '0 : p_hi[PRES_W-1:0];
        n_t_val = (t_neg || n_t_bad) ? '0 : t_hi[TEMP_W-1:0];
    end

    logic r_out_valid;
    logic [PRES_W-1:0] r_p_val;
    logic [TEMP_W-1:0] r_t_val;
    logic              r_p_bad, r_t_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= tail.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_val <= n_p_val;
            r_t_val <= n_t_val;
            r_p_bad <= n_p_bad;
            r_t_bad <= n_t_bad;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_pressure_tenths_mbar = r_p_val;
    assign o_temperature_tenths_c = r_t_val;
    assign o_pressure_invalid     = r_p_bad;
    assign o_temperature_invalid  = r_t_bad;

    // Flagged results carry a zero field.
    a_p_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pressure_invalid |-> o_pressure_tenths_mbar == '0)
        else $error("pressure flagged invalid with nonzero value");

    a_t_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_temperature_invalid |-> o_temperature_tenths_c == '0)
        else $error("temperature flagged invalid with nonzero value");

    // Unflagged results are in range.
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_pressure_tenths_mbar <= PRES_W'(ptc_pkg::PRES_MAX))
            && (o_temperature_tenths_c <= TEMP_W'(ptc_pkg::TEMP_MAX)))
        else $error("result field above range");

    // An item in the last datapath stage reaches the output on the next
    // advance.
    a_tail_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && tail.valid |=> o_out_valid)
        else $error("item lost between last stage and output");

endmodule
